// File: src/ipv6t_pkg.sv
`default_nettype none

package ipv6t_pkg;

	// depth of the queue between classifier and text sequencer
	localparam int QueueDepth = 2;

	// ascii codes used by the text sequencer
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_HEXA  = 8'h57;

	localparam logic [3:0] GroupCount = 4'd8;

	// one classified address waiting for text output
	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
		logic        has_run;
		logic [2:0]  run_base;
		logic [3:0]  run_end;
		logic        dotted;
	} entry_t;

	// 16-bit group g of the address, group 0 most significant
	function automatic logic [15:0] group_of(input logic [127:0] a, input logic [2:0] g);
		logic [6:0] lsb;
		lsb = {~g, 4'b0000};
		return a[lsb +: 16];
	endfunction

	// index of the most significant nonzero nibble, 0 for a zero group
	function automatic logic [1:0] first_nibble(input logic [15:0] v);
		logic [1:0] r;
		if (v[15:12] != 4'h0) r = 2'd3;
		else if (v[11:8] != 4'h0) r = 2'd2;
		else if (v[7:4] != 4'h0) r = 2'd1;
		else r = 2'd0;
		return r;
	endfunction

	// lowercase hex digit
	function automatic logic [7:0] hex_char(input logic [3:0] d);
		logic [7:0] r;
		if (d < 4'd10) r = CH_ZERO + {4'b0000, d};
		else r = CH_HEXA + {4'b0000, d};
		return r;
	endfunction

	// index of the leading decimal digit of a byte
	function automatic logic [1:0] dec_start(input logic [7:0] v);
		logic [1:0] r;
		if (v >= 8'd100) r = 2'd2;
		else if (v >= 8'd10) r = 2'd1;
		else r = 2'd0;
		return r;
	endfunction

endpackage

`default_nettype wire

// File: src/ipv6t_addr_if.sv
`default_nettype none

interface ipv6t_addr_if;
	logic        valid;
	logic        ready;
	logic [63:0] addr_high;
	logic [63:0] addr_low;

	modport source(output valid, output addr_high, output addr_low, input ready);
	modport sink(input valid, input addr_high, input addr_low, output ready);
endinterface

`default_nettype wire

// File: src/ipv6t_text_if.sv
`default_nettype none

interface ipv6t_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       is_last;

	modport source(output valid, output char_code, output is_last, input ready);
	modport sink(input valid, input char_code, input is_last, output ready);
endinterface

`default_nettype wire

// File: src/ipv6t_front.sv
`default_nettype none

module ipv6t_front import ipv6t_pkg::*; (
	ipv6t_addr_if.sink addr,
	output logic       push_valid,
	input  logic       push_ready,
	output entry_t     push_data
);

	logic [127:0] full_addr;
	logic [3:0]   best_len;
	logic [2:0]   best_base;
	logic [3:0]   cur_len;
	logic [2:0]   cur_base;
	logic [15:0]  grp;

	assign full_addr = {addr.addr_high, addr.addr_low};

	// longest run of zero groups, first run wins a tie
	always_comb begin
		best_len  = 4'd0;
		best_base = 3'd0;
		cur_len   = 4'd0;
		cur_base  = 3'd0;
		grp       = 16'h0000;
		for (int i = 0; i < 8; i++) begin
			grp = group_of(full_addr, 3'(i));
			if (grp == 16'h0000) begin
				if (cur_len == 4'd0) begin
					cur_base = 3'(i);
				end
				cur_len = cur_len + 4'd1;
			end else begin
				if (cur_len > best_len) begin
					best_len  = cur_len;
					best_base = cur_base;
				end
				cur_len = 4'd0;
			end
		end
		if (cur_len > best_len) begin
			best_len  = cur_len;
			best_base = cur_base;
		end
	end

	// classified entry into the queue
	always_comb begin
		push_data.hi       = addr.addr_high;
		push_data.lo       = addr.addr_low;
		push_data.has_run  = (best_len >= 4'd2);
		push_data.run_base = best_base;
		push_data.run_end  = {1'b0, best_base} + best_len;
		push_data.dotted   = (best_len >= 4'd2) && (best_base == 3'd0) &&
		                     ((best_len == 4'd6) ||
		                      ((best_len == 4'd5) && (addr.addr_low[47:32] == 16'hffff)));
	end

	assign push_valid = addr.valid;
	assign addr.ready = push_ready;

endmodule

`default_nettype wire

// File: src/ipv6t_queue.sv
`default_nettype none

module ipv6t_queue import ipv6t_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push_valid,
	output logic   push_ready,
	input  entry_t push_data,
	output logic   pop_valid,
	input  logic   pop_ready,
	output entry_t pop_data
);

	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW = $clog2(QueueDepth + 1);

	entry_t          mem_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != CntW'(QueueDepth));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: src/ipv6t_back.sv
`default_nettype none

module ipv6t_back import ipv6t_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         head_valid,
	input  entry_t       head,
	output logic         pop,
	ipv6t_text_if.source text
);

	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_SEP  = 3'd1;
	localparam logic [2:0] ST_HEX  = 3'd2;
	localparam logic [2:0] ST_RUN  = 3'd3;
	localparam logic [2:0] ST_DEC  = 3'd4;
	localparam logic [2:0] ST_DOT  = 3'd5;
	localparam logic [2:0] ST_TAIL = 3'd6;

	logic [2:0]   state_q;
	logic [2:0]   grp_q;
	logic [1:0]   nib_q;
	logic [1:0]   byte_q;
	logic [1:0]   dig_q;
	logic         out_valid_q;
	logic [7:0]   out_char_q;
	logic         out_last_q;

	logic [127:0] full_addr;
	logic [15:0]  cur_grp;
	logic [2:0]   st;
	logic [1:0]   nib;
	logic [3:0]   nib_val;
	logic [2:0]   grp_inc;
	logic [2:0]   enter_st;
	logic [7:0]   byte_val;
	logic [1:0]   hund;
	logic [7:0]   rem8;
	logic [6:0]   rem;
	logic [14:0]  prod;
	logic [3:0]   tens;
	logic [6:0]   ones7;
	logic [3:0]   digit;
	logic         adv;

	logic [7:0]   ch;
	logic         last;
	logic [2:0]   st_nx;
	logic [2:0]   grp_nx;
	logic [1:0]   nib_nx;
	logic [1:0]   byte_nx;
	logic [1:0]   dig_nx;

	assign full_addr = {head.hi, head.lo};
	assign cur_grp   = group_of(full_addr, grp_q);

	// the first character of an address acts as a run or a hex state
	always_comb begin
		if (state_q == ST_INIT) begin
			st  = (head.has_run && (head.run_base == 3'd0)) ? ST_RUN : ST_HEX;
			nib = first_nibble(cur_grp);
		end else begin
			st  = state_q;
			nib = nib_q;
		end
	end

	assign nib_val  = cur_grp[{nib, 2'b00} +: 4];
	assign grp_inc  = grp_q + 3'd1;
	assign enter_st = (head.has_run && (grp_inc == head.run_base)) ? ST_RUN : ST_SEP;

	// decimal digits of the current byte of the dotted tail
	assign byte_val = head.lo[{~byte_q, 3'b000} +: 8];
	always_comb begin
		if (byte_val >= 8'd200) hund = 2'd2;
		else if (byte_val >= 8'd100) hund = 2'd1;
		else hund = 2'd0;
	end
	assign rem8  = byte_val - 8'({6'b0, hund} * 8'd100);
	assign rem   = rem8[6:0];
	assign prod  = {8'b0, rem} * 15'd205;
	assign tens  = prod[14:11];
	assign ones7 = rem - 7'({3'b0, tens} * 7'd10);

	always_comb begin
		case (dig_q)
			2'd2:    digit = {2'b00, hund};
			2'd1:    digit = tens;
			default: digit = ones7[3:0];
		endcase
	end

	// character sequencer
	always_comb begin
		ch      = CH_COLON;
		last    = 1'b0;
		st_nx   = st;
		grp_nx  = grp_q;
		nib_nx  = nib;
		byte_nx = byte_q;
		dig_nx  = dig_q;
		case (st)
			ST_RUN: begin
				ch = CH_COLON;
				if (head.run_end == GroupCount) begin
					st_nx = ST_TAIL;
				end else begin
					st_nx  = ST_SEP;
					grp_nx = head.run_end[2:0];
				end
			end
			ST_TAIL: begin
				ch   = CH_COLON;
				last = 1'b1;
			end
			ST_SEP: begin
				ch = CH_COLON;
				if (head.dotted && (grp_q == 3'd6)) begin
					st_nx  = ST_DEC;
					dig_nx = dec_start(head.lo[31:24]);
				end else begin
					st_nx  = ST_HEX;
					nib_nx = first_nibble(cur_grp);
				end
			end
			ST_HEX: begin
				ch = hex_char(nib_val);
				if (nib == 2'd0) begin
					if (grp_q == 3'd7) begin
						last = 1'b1;
					end else begin
						grp_nx = grp_inc;
						st_nx  = enter_st;
					end
				end else begin
					nib_nx = nib - 2'd1;
				end
			end
			ST_DEC: begin
				ch = CH_ZERO + {4'b0000, digit};
				if (dig_q == 2'd0) begin
					if (byte_q == 2'd3) begin
						last = 1'b1;
					end else begin
						st_nx   = ST_DOT;
						byte_nx = byte_q + 2'd1;
					end
				end else begin
					dig_nx = dig_q - 2'd1;
				end
			end
			ST_DOT: begin
				ch     = CH_DOT;
				st_nx  = ST_DEC;
				dig_nx = dec_start(byte_val);
			end
			default: begin
				ch = CH_COLON;
			end
		endcase
	end

	assign adv = head_valid && (!out_valid_q || text.ready);
	assign pop = adv && last;

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			grp_q   <= 3'd0;
			nib_q   <= 2'd0;
			byte_q  <= 2'd0;
			dig_q   <= 2'd0;
		end else if (adv) begin
			if (last) begin
				state_q <= ST_INIT;
				grp_q   <= 3'd0;
				byte_q  <= 2'd0;
			end else begin
				state_q <= st_nx;
				grp_q   <= grp_nx;
				byte_q  <= byte_nx;
			end
			nib_q <= nib_nx;
			dig_q <= dig_nx;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (text.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_char_q <= ch;
			out_last_q <= last;
		end
	end

	assign text.valid     = out_valid_q;
	assign text.char_code = out_char_q;
	assign text.is_last   = out_last_q;

endmodule

`default_nettype wire

// File: src/ipv6_address_to_text_unit.sv
// channel  dir  payload                          transfer when
// addr     in   addr_high[63:0], addr_low[63:0]  addr.valid && addr.ready
// text     out  char_code[7:0], is_last          text.valid && text.ready
//
// one character leaves per cycle while the text channel is ready; the text of
// an address has 2 to 39 characters, set by the single character sequencer
// a two-entry queue holds classified addresses, so input is taken while
// text of an earlier address is still being sent
// arst_n clears queue, sequencer and output valid; a stalled text holds
`default_nettype none

module ipv6_address_to_text_unit import ipv6t_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	ipv6t_addr_if.sink   addr,
	ipv6t_text_if.source text
);

	logic   push_valid;
	logic   push_ready;
	entry_t push_data;
	logic   head_valid;
	entry_t head;
	logic   pop;

	// classify the zero run of each address
	ipv6t_front u_front (
		.addr       (addr),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// decouple classification from text output
	ipv6t_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (head_valid),
		.pop_ready  (pop),
		.pop_data   (head)
	);

	// emit text one character per cycle while the text channel is ready
	ipv6t_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.text       (text)
	);

endmodule

`default_nettype wire

// File: tb/sv/ipv6_address_to_text_check.sv
`default_nettype none

module ipv6_address_to_text_check import ipv6t_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	ipv6t_addr_if  addr,
	ipv6t_text_if  text,
	output int     pending,
	output int     mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} text_char_t;

	// characters still owed by the block, oldest first
	text_char_t text_due [$];

	initial begin
		pending = 0;
		mismatches = 0;
	end

	// compressed text of one address, appended to the characters owed
	function automatic void predict_text(input logic [63:0] hi, input logic [63:0] lo);
		logic [15:0] grp [8];
		logic [7:0] txt [$];
		logic [7:0] oct;
		logic [3:0] nib;
		int best_base;
		int best_len;
		int cur_base;
		int cur_len;
		bit started;
		bit dotted;
		text_char_t due;
		best_base = -1;
		best_len = 0;
		cur_base = -1;
		cur_len = 0;
		for (int i = 0; i < 4; i++) begin
			grp[i] = hi[63 - 16 * i -: 16];
			grp[i + 4] = lo[63 - 16 * i -: 16];
		end

		// longest run of zero groups, first one wins a tie
		for (int i = 0; i < 8; i++) begin
			if (grp[i] == 16'h0000) begin
				if (cur_base < 0) begin
					cur_base = i;
					cur_len = 1;
				end else begin
					cur_len++;
				end
			end else if (cur_base >= 0) begin
				if (best_base < 0 || cur_len > best_len) begin
					best_base = cur_base;
					best_len = cur_len;
				end
				cur_base = -1;
			end
		end
		if (cur_base >= 0 && (best_base < 0 || cur_len > best_len)) begin
			best_base = cur_base;
			best_len = cur_len;
		end
		if (best_base >= 0 && best_len < 2)
			best_base = -1;

		// embedded ipv4: compatible or mapped form
		dotted = best_base == 0 && (best_len == 6 || (best_len == 5 && grp[5] == 16'hffff));

		for (int i = 0; i < 8; i++) begin
			if (best_base >= 0 && i >= best_base && i < best_base + best_len) begin
				if (i == best_base)
					txt.push_back(CH_COLON);
			end else begin
				if (i != 0)
					txt.push_back(CH_COLON);
				if (i == 6 && dotted) begin
					for (int b = 3; b >= 0; b--) begin
						oct = lo[8 * b +: 8];
						if (oct >= 8'd100)
							txt.push_back(CH_ZERO + oct / 8'd100);
						if (oct >= 8'd10)
							txt.push_back(CH_ZERO + (oct / 8'd10) % 8'd10);
						txt.push_back(CH_ZERO + oct % 8'd10);
						if (b != 0)
							txt.push_back(CH_DOT);
					end
					break;
				end
				// hex group without leading zeros
				started = 1'b0;
				for (int s = 3; s >= 0; s--) begin
					nib = grp[i][4 * s +: 4];
					if (nib != 4'h0 || started || s == 0) begin
						txt.push_back(nib < 4'd10 ? CH_ZERO + nib : CH_HEXA + nib);
						started = 1'b1;
					end
				end
			end
		end
		// run reaching the end leaves a closing colon
		if (best_base >= 0 && best_base + best_len == 8)
			txt.push_back(CH_COLON);

		foreach (txt[k]) begin
			due.code = txt[k];
			due.last = (k == txt.size() - 1);
			text_due.push_back(due);
		end
	endfunction

	// predict on each address transfer, compare on each text transfer
	always @(posedge clk) begin
		text_char_t due;
		if (arst_n) begin
			if (addr.valid && addr.ready)
				predict_text(addr.addr_high, addr.addr_low);
			if (text.valid && text.ready) begin
				if (text_due.size() == 0) begin
					$display("%0t ns: unexpected character, expected none, got %h last %b",
						$time, text.char_code, text.is_last);
					mismatches++;
				end else begin
					due = text_due.pop_front();
					if (text.char_code !== due.code) begin
						$display("%0t ns: char_code expected %h, got %h",
							$time, due.code, text.char_code);
						mismatches++;
					end
					if (text.is_last !== due.last) begin
						$display("%0t ns: is_last expected %b, got %b",
							$time, due.last, text.is_last);
						mismatches++;
					end
				end
			end
			pending = text_due.size();
		end
	end

endmodule

`default_nettype wire

// File: tb/sv/ipv6_address_to_text_unit_tb.sv
`default_nettype none

module ipv6_address_to_text_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	int   pending;
	int   mismatches;
	bit   calm = 1'b0;
	bit   hold_req = 1'b0;

	ipv6t_addr_if addr_ch();
	ipv6t_text_if text_ch();

	ipv6_address_to_text_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.addr   (addr_ch),
		.text   (text_ch)
	);

	ipv6_address_to_text_check text_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.addr       (addr_ch),
		.text       (text_ch),
		.pending    (pending),
		.mismatches (mismatches)
	);

	// hand-picked addresses covering the corner cases of the text form
	logic [127:0] addr_cases [23] = '{
		128'h0000_0000_0000_0000_0000_0000_0000_0000,
		128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff,
		128'h0001_0000_0002_0003_0004_0005_0006_0007,
		128'h0001_0002_0003_0004_0005_0006_0000_0000,
		128'h0000_0000_0000_0000_0000_0000_0000_0001,
		128'h0000_0000_0000_0000_0000_0000_c0a8_0101,
		128'h0000_0000_0000_0000_0000_ffff_0a00_00ff,
		128'h0000_0000_0000_0000_0000_fffe_0a00_00ff,
		128'h0000_0000_0000_0000_0000_0000_0001_0000,
		128'h0001_0000_0000_0002_0000_0000_0003_0004,
		128'h0001_0000_0000_0002_0000_0000_0000_0003,
		128'h2001_0db8_0000_0000_0000_8a2e_0370_7334,
		128'h0001_0000_0000_0000_0000_ffff_0102_0304,
		128'h0000_0000_0000_0000_0000_0000_ffff_ffff,
		128'h0000_0000_0000_0000_0000_ffff_ffff_ffff,
		128'h0000_0000_0000_0000_ffff_ffff_ffff_ffff,
		128'h0000_0001_0000_0001_0000_0001_0000_0001,
		128'hffff_ffff_ffff_ffff_0000_0000_0000_0000,
		128'h000f_00f0_0f00_f000_0009_00a0_0b00_c000,
		128'h0000_ffff_0000_0000_0000_0000_0000_0001,
		128'h0000_0000_0000_0000_0000_ffff_0000_0000,
		128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210,
		128'h0000_0000_0001_0000_0000_0000_0000_0000
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	// text receiver: short stalls, one long hold-off on request
	initial begin
		text_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				text_ch.ready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				text_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				text_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// offer one address, with an occasional idle burst ahead of it
	task automatic offer_address(input logic [63:0] hi, input logic [63:0] lo);
		if (!calm && $urandom_range(0, 3) == 0) begin
			addr_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		addr_ch.valid <= 1'b1;
		addr_ch.addr_high <= hi;
		addr_ch.addr_low <= lo;
		do @(posedge clk); while (!addr_ch.ready);
	endtask

	initial begin
		logic [127:0] a;
		logic [15:0] grp;
		int pick;
		arst_n <= 1'b0;
		addr_ch.valid <= 1'b0;
		addr_ch.addr_high <= '0;
		addr_ch.addr_low <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (addr_cases[k])
			offer_address(addr_cases[k][127:64], addr_cases[k][63:0]);

		for (int n = 0; n < 260; n++) begin
			// receiver holds off while addresses keep coming
			if (n == 40)
				hold_req = 1'b1;
			// sender drains the block completely once
			if (n == 120) begin
				addr_ch.valid <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
			end
			if (n == 210)
				calm = 1'b1;

			pick = $urandom_range(0, 9);
			if (pick < 3) begin
				a = {$urandom, $urandom, $urandom, $urandom};
			end else begin
				// groups biased toward zero runs and short values
				for (int g = 0; g < 8; g++) begin
					case ($urandom_range(0, 7))
						0, 1, 2: grp = 16'h0000;
						3: grp = 16'hffff;
						4: grp = 16'($urandom_range(1, 15) << (4 * $urandom_range(0, 3)));
						default: grp = 16'($urandom);
					endcase
					a[127 - 16 * g -: 16] = grp;
				end
				// embedded ipv4, octets of one to three digits
				if (pick == 9) begin
					a[127:48] = '0;
					a[47:32] = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
					for (int b = 0; b < 4; b++)
						a[8 * b +: 8] = $urandom_range(0, 2) == 0 ?
							8'($urandom_range(0, 9)) : 8'($urandom_range(0, 255));
				end
			end
			offer_address(a[127:64], a[63:0]);
		end
		addr_ch.valid <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// File: ipv6_address_to_text_unit.f
src/ipv6t_pkg.sv
src/ipv6t_addr_if.sv
src/ipv6t_text_if.sv
src/ipv6t_front.sv
src/ipv6t_queue.sv
src/ipv6t_back.sv
src/ipv6_address_to_text_unit.sv
tb/sv/ipv6_address_to_text_check.sv
tb/sv/ipv6_address_to_text_unit_tb.sv
